/* hw/rtl/cascaded_biquad_iir_filter_top_assert.svh */
// Assertion macros shared by the filter RTL.
`ifndef CASCADED_BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BIQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define BIQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/biq_pkg.sv */
`default_nettype none

package biq_pkg;

  // Sizes of the filter
  localparam int MAX_SECTIONS = 8;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int STATE_WIDTH  = 40;
  localparam int COEF_FRAC    = COEF_WIDTH - 4;

  // Item field widths
  localparam int MODE_W = 2;
  localparam int SEC_W  = 3;
  localparam int SLOT_W = 3;
  localparam int CFG_W  = 4;

  // Stores
  localparam int COEF_SLOTS  = 5;
  localparam int DELAY_SLOTS = 2;
  localparam int COEF_DEPTH  = MAX_SECTIONS * COEF_SLOTS;
  localparam int DELAY_DEPTH = MAX_SECTIONS * DELAY_SLOTS;
  localparam int COEF_AW     = $clog2(COEF_DEPTH);
  localparam int DELAY_AW    = $clog2(DELAY_DEPTH);

  // Multiplier split: delay word cut into a low unsigned and a high signed half
  localparam int LO_W      = STATE_WIDTH / 2;
  localparam int PROD_W    = COEF_WIDTH + LO_W + 1;
  localparam int ACC_WIDTH = COEF_WIDTH + STATE_WIDTH + 3;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_FILTER     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_COEF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_STATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ_STATE = 2'd3;

  // Coefficient slots within a section
  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // Multiplier second operand select
  typedef logic [1:0] opb_sel_t;
  localparam opb_sel_t OPB_MEM = 2'd0;
  localparam opb_sel_t OPB_W   = 2'd1;
  localparam opb_sel_t OPB_S0  = 2'd2;
  localparam opb_sel_t OPB_S1  = 2'd3;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic              capture;
    logic              coef_load;
    logic              delay_load;
    logic              rd_user;
    logic [SEC_W-1:0]  section;
    logic              rd_coef;
    logic [SLOT_W-1:0] coef_slot;
    logic              rd_delay;
    logic              delay_slot;
    logic              acc_init;
    logic              acc_clr;
    logic              acc_add;
    logic              mul_en;
    logic              mul_sub;
    opb_sel_t          opb_sel;
    logic              s0_latch;
    logic              s1_latch;
    logic              w_latch;
    logic              y_latch;
    logic              wb_s0;
    logic              wb_w;
    logic              out_load;
    logic              out_rd;
  } biq_cmd_t;

  // Coefficient store address: five words per section
  function automatic logic [COEF_AW-1:0] coef_addr(input logic [SEC_W-1:0] sec,
                                                   input logic [SLOT_W-1:0] slot);
    coef_addr = (COEF_AW'(sec) << 2) + COEF_AW'(sec) + COEF_AW'(slot);
  endfunction

  // Delay store address: two words per section
  function automatic logic [DELAY_AW-1:0] delay_addr(input logic [SEC_W-1:0] sec,
                                                     input logic slot);
    delay_addr = (DELAY_AW'(sec) << 1) | DELAY_AW'(slot);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cascaded_biquad_iir_filter_top.sv */
// Cascade of second-order IIR sections (direct form II), fixed point.
// Input channel (in_valid/in_ready) carries one beat per item; mode picks
// filter sample, load coefficient, load delay word, or read delay word.
// Output channel (out_valid/out_ready) carries one beat per filtered sample
// or readback; loads produce no output beat.
// cfg_we/cfg_data write the active section count (0 acts as 1, values above
// eight act as eight); write it only while the block is idle.
// With N active sections, a filter beat steps through the sections in turn
// on one shared multiplier pair and accumulator and then passes to the
// finish stage, which loads the output register; a readback goes from
// accept straight to the finish stage. The next input is taken once the
// finish stage has loaded its result; loads complete in the accept cycle.
// Reset (rst, synchronous) clears all coefficients and delay words to zero
// through per-entry valid bits, sets the section count to one and empties
// the output register. The block takes the next input while a result waits;
// if the receiver stalls, the following result holds in the finish stage
// and no further input is accepted until the output register frees.
`default_nettype none

module cascaded_biquad_iir_filter_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic        [biq_pkg::MODE_W-1:0]        mode,
  input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0]  sample_in,
  input  logic        [biq_pkg::SEC_W-1:0]         section_index,
  input  logic        [biq_pkg::SLOT_W-1:0]        slot_index,
  input  logic signed [biq_pkg::COEF_WIDTH-1:0]    coef_value,
  input  logic signed [biq_pkg::STATE_WIDTH-1:0]   state_value,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [biq_pkg::SAMPLE_WIDTH-1:0]  filtered_out,
  output logic                                     saturated,
  output logic signed [biq_pkg::STATE_WIDTH-1:0]   state_readback,
  output logic                                     is_readback,
  input  logic                                     cfg_we,
  input  logic        [biq_pkg::CFG_W-1:0]         cfg_data
);
  import biq_pkg::*;

  biq_cmd_t cmd;

  // Sequencer
  biq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  // Stores, multiplier and accumulator
  biq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sample_in      (sample_in),
    .section_index  (section_index),
    .slot_index     (slot_index),
    .coef_value     (coef_value),
    .state_value    (state_value),
    .filtered_out   (filtered_out),
    .saturated      (saturated),
    .state_readback (state_readback),
    .is_readback    (is_readback)
  );

endmodule

`default_nettype wire

/* hw/rtl/biq_datapath.sv */
`default_nettype none

`include "cascaded_biquad_iir_filter_top_assert.svh"

module biq_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  biq_pkg::biq_cmd_t                        cmd,
  input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0]  sample_in,
  input  logic        [biq_pkg::SEC_W-1:0]         section_index,
  input  logic        [biq_pkg::SLOT_W-1:0]        slot_index,
  input  logic signed [biq_pkg::COEF_WIDTH-1:0]    coef_value,
  input  logic signed [biq_pkg::STATE_WIDTH-1:0]   state_value,
  output logic signed [biq_pkg::SAMPLE_WIDTH-1:0]  filtered_out,
  output logic                                     saturated,
  output logic signed [biq_pkg::STATE_WIDTH-1:0]   state_readback,
  output logic                                     is_readback
);
  import biq_pkg::*;

  localparam int SH_W = ACC_WIDTH - COEF_FRAC;
  localparam logic signed [ACC_WIDTH-1:0] ACC_HALF =
    ACC_WIDTH'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Stores and their read registers
  logic signed [COEF_WIDTH-1:0]  coef_mem [COEF_DEPTH];
  logic        [COEF_DEPTH-1:0]  coef_vld;
  logic signed [COEF_WIDTH-1:0]  coef_q;
  logic signed [STATE_WIDTH-1:0] dly_mem [DELAY_DEPTH];
  logic        [DELAY_DEPTH-1:0] dly_vld;
  logic signed [STATE_WIDTH-1:0] delay_q;

  // Working registers
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [STATE_WIDTH-1:0]  s0;
  logic signed [STATE_WIDTH-1:0]  s1;
  logic signed [STATE_WIDTH-1:0]  w;
  logic signed [PROD_W-1:0]       p_lo;
  logic signed [PROD_W-1:0]       p_hi;
  logic                           p_sub;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic                           clip;

  logic                           sec_ok;
  logic                           coef_ld_ok;
  logic                           dly_ld_ok;
  logic [COEF_AW-1:0]             coef_ld_addr;
  logic [COEF_AW-1:0]             coef_rd_addr;
  logic [DELAY_AW-1:0]            dly_ld_addr;
  logic                           dly_we;
  logic [DELAY_AW-1:0]            dly_wa;
  logic signed [STATE_WIDTH-1:0]  dly_wd;
  logic                           dly_re;
  logic [DELAY_AW-1:0]            dly_ra;
  logic                           dly_rd_ok;
  logic signed [STATE_WIDTH-1:0]  opb;
  logic signed [ACC_WIDTH-1:0]    prod_sum;
  logic signed [SH_W-1:0]         sh;
  logic [SH_W-STATE_WIDTH:0]      w_top;
  logic [SH_W-SAMPLE_WIDTH:0]     y_top;
  logic                           w_ovf;
  logic                           y_ovf;
  logic signed [STATE_WIDTH-1:0]  w_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  // Decode the address of a load or a readback
  assign sec_ok       = {1'b0, section_index} < (SEC_W + 1)'(MAX_SECTIONS);
  assign coef_ld_ok   = sec_ok && (slot_index < SLOT_W'(COEF_SLOTS));
  assign dly_ld_ok    = sec_ok && (slot_index < SLOT_W'(DELAY_SLOTS));
  assign coef_ld_addr = coef_addr(section_index, slot_index);
  assign dly_ld_addr  = delay_addr(section_index, slot_index[0]);
  assign coef_rd_addr = coef_addr(cmd.section, cmd.coef_slot);

  // Coefficient store: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.coef_load && coef_ld_ok) begin
      coef_mem[coef_ld_addr] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (cmd.coef_load && coef_ld_ok) begin
      coef_vld[coef_ld_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_coef) begin
      coef_q <= coef_vld[coef_rd_addr] ? coef_mem[coef_rd_addr] : '0;
    end
  end

  // Delay store write port: user load or section write-back
  always_comb begin
    dly_we = 1'b0;
    dly_wa = delay_addr(cmd.section, 1'b0);
    dly_wd = w;
    if (cmd.delay_load && dly_ld_ok) begin
      dly_we = 1'b1;
      dly_wa = dly_ld_addr;
      dly_wd = state_value;
    end else if (cmd.wb_w) begin
      dly_we = 1'b1;
    end else if (cmd.wb_s0) begin
      dly_we = 1'b1;
      dly_wa = delay_addr(cmd.section, 1'b1);
      dly_wd = s0;
    end
  end

  // Delay store read port: user readback or section fetch
  assign dly_re    = cmd.rd_user | cmd.rd_delay;
  assign dly_ra    = cmd.rd_user ? dly_ld_addr : delay_addr(cmd.section, cmd.delay_slot);
  assign dly_rd_ok = cmd.rd_user ? dly_ld_ok : 1'b1;

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld <= '0;
    end else if (dly_we) begin
      dly_vld[dly_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dly_re) begin
      delay_q <= (dly_rd_ok && dly_vld[dly_ra]) ? dly_mem[dly_ra] : '0;
    end
  end

  // Multiplier operand select
  always_comb begin
    case (cmd.opb_sel)
      OPB_MEM: opb = delay_q;
      OPB_W:   opb = w;
      OPB_S0:  opb = s0;
      OPB_S1:  opb = s1;
      default: opb = delay_q;
    endcase
  end

  // Two half-width partial products, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_lo  <= PROD_W'(coef_q) * PROD_W'($signed({1'b0, opb[LO_W-1:0]}));
      p_hi  <= PROD_W'(coef_q) * PROD_W'($signed(opb[STATE_WIDTH-1:LO_W]));
      p_sub <= cmd.mul_sub;
    end
  end

  assign prod_sum = (ACC_WIDTH'(p_hi) <<< LO_W) + ACC_WIDTH'(p_lo);

  // Accumulator, preloaded with the rounding half
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc <= (ACC_WIDTH'(x) <<< COEF_FRAC) + ACC_HALF;
    end else if (cmd.acc_clr) begin
      acc <= ACC_HALF;
    end else if (cmd.acc_add) begin
      acc <= p_sub ? acc - prod_sum : acc + prod_sum;
    end
  end

  // Drop fraction bits and clip to the delay word or the sample
  assign sh    = acc[ACC_WIDTH-1:COEF_FRAC];
  assign w_top = sh[SH_W-1:STATE_WIDTH-1];
  assign y_top = sh[SH_W-1:SAMPLE_WIDTH-1];
  assign w_ovf = ~((&w_top) | ~(|w_top));
  assign y_ovf = ~((&y_top) | ~(|y_top));
  assign w_sat = w_ovf ? (sh[SH_W-1] ? STATE_MIN : STATE_MAX) : sh[STATE_WIDTH-1:0];
  assign y_sat = y_ovf ? (sh[SH_W-1] ? SAMPLE_MIN : SAMPLE_MAX) : sh[SAMPLE_WIDTH-1:0];

  // Section input, delay words and intermediate w
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x <= sample_in;
    end else if (cmd.y_latch) begin
      x <= y_sat;
    end
    if (cmd.s0_latch) begin
      s0 <= delay_q;
    end
    if (cmd.s1_latch) begin
      s1 <= delay_q;
    end
    if (cmd.w_latch) begin
      w <= w_sat;
    end
  end

  // Clip flag covers the current sample only
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      clip <= 1'b0;
    end else if ((cmd.w_latch && w_ovf) || (cmd.y_latch && y_ovf)) begin
      clip <= 1'b1;
    end
  end

  // Output register for the result beat
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_out   <= cmd.out_rd ? '0 : x;
      saturated      <= cmd.out_rd ? 1'b0 : clip;
      state_readback <= cmd.out_rd ? delay_q : '0;
      is_readback    <= cmd.out_rd;
    end
  end

  // A write-back never collides with a user load
  `BIQ_ASSERT_IMPLY(a_wb_excl, clk, rst, cmd.wb_w || cmd.wb_s0, !cmd.delay_load && !cmd.coef_load, "write-back during a load")
  // The slot-0 write-back follows the slot-1 write-back of the same section
  `BIQ_ASSERT_IMPLY(a_wb_order, clk, rst, cmd.wb_w, $past(cmd.wb_s0) && ($past(cmd.section) == cmd.section), "write-back out of order")
  // The delay store is written back only from a freshly latched w
  `BIQ_ASSERT_IMPLY(a_wb_fresh, clk, rst, cmd.wb_w, $past(cmd.w_latch), "stale w written back")

endmodule

`default_nettype wire

/* hw/rtl/biq_ctrl.sv */
`default_nettype none

`include "cascaded_biquad_iir_filter_top_assert.svh"

module biq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [biq_pkg::MODE_W-1:0]  mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        cfg_we,
  input  logic [biq_pkg::CFG_W-1:0]   cfg_data,
  output biq_pkg::biq_cmd_t           cmd
);
  import biq_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FILT   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Steps of one section
  localparam logic [3:0] STEP_RD_S0  = 4'd0;
  localparam logic [3:0] STEP_MUL_A1 = 4'd1;
  localparam logic [3:0] STEP_MUL_A2 = 4'd2;
  localparam logic [3:0] STEP_ACC_A2 = 4'd3;
  localparam logic [3:0] STEP_W      = 4'd4;
  localparam logic [3:0] STEP_MUL_B0 = 4'd5;
  localparam logic [3:0] STEP_MUL_B1 = 4'd6;
  localparam logic [3:0] STEP_MUL_B2 = 4'd7;
  localparam logic [3:0] STEP_ACC_B2 = 4'd8;
  localparam logic [3:0] STEP_Y      = 4'd9;

  logic [1:0]       state, state_next;
  logic [3:0]       step, step_next;
  logic [SEC_W-1:0] section, section_next;
  logic             is_rd, is_rd_next;
  logic             out_valid_next;
  logic [CFG_W-1:0] active_sections;
  logic [CFG_W-1:0] n_clamped;
  logic [SEC_W-1:0] last_sec;
  logic             accept;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= CFG_W'(1);
    end else if (cfg_we) begin
      active_sections <= cfg_data;
    end
  end

  // Clamp the section count into range
  always_comb begin
    if (active_sections == '0) begin
      n_clamped = CFG_W'(1);
    end else if (active_sections > CFG_W'(MAX_SECTIONS)) begin
      n_clamped = CFG_W'(MAX_SECTIONS);
    end else begin
      n_clamped = active_sections;
    end
  end

  assign last_sec = SEC_W'(n_clamped - CFG_W'(1));
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and datapath commands
  always_comb begin
    state_next   = state;
    step_next    = step;
    section_next = section;
    is_rd_next   = is_rd;
    cmd          = '0;
    cmd.section  = section;
    cmd.opb_sel  = OPB_MEM;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          case (mode)
            MODE_FILTER: begin
              state_next   = ST_FILT;
              step_next    = STEP_RD_S0;
              section_next = '0;
              is_rd_next   = 1'b0;
            end
            MODE_LOAD_COEF: begin
              cmd.coef_load = 1'b1;
            end
            MODE_LOAD_STATE: begin
              cmd.delay_load = 1'b1;
            end
            MODE_READ_STATE: begin
              cmd.rd_user = 1'b1;
              state_next  = ST_FINISH;
              is_rd_next  = 1'b1;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILT: begin
        step_next = step + 4'd1;
        case (step)
          STEP_RD_S0: begin
            cmd.rd_delay   = 1'b1;
            cmd.delay_slot = 1'b0;
            cmd.rd_coef    = 1'b1;
            cmd.coef_slot  = SLOT_A1;
            cmd.acc_init   = 1'b1;
          end
          STEP_MUL_A1: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_sub    = 1'b1;
            cmd.s0_latch   = 1'b1;
            cmd.rd_delay   = 1'b1;
            cmd.delay_slot = 1'b1;
            cmd.rd_coef    = 1'b1;
            cmd.coef_slot  = SLOT_A2;
          end
          STEP_MUL_A2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sub   = 1'b1;
            cmd.s1_latch  = 1'b1;
            cmd.acc_add   = 1'b1;
            cmd.rd_coef   = 1'b1;
            cmd.coef_slot = SLOT_B0;
          end
          STEP_ACC_A2: begin
            cmd.acc_add = 1'b1;
          end
          STEP_W: begin
            cmd.w_latch = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.wb_s0   = 1'b1;
          end
          STEP_MUL_B0: begin
            cmd.mul_en    = 1'b1;
            cmd.opb_sel   = OPB_W;
            cmd.rd_coef   = 1'b1;
            cmd.coef_slot = SLOT_B1;
            cmd.wb_w      = 1'b1;
          end
          STEP_MUL_B1: begin
            cmd.mul_en    = 1'b1;
            cmd.opb_sel   = OPB_S0;
            cmd.acc_add   = 1'b1;
            cmd.rd_coef   = 1'b1;
            cmd.coef_slot = SLOT_B2;
          end
          STEP_MUL_B2: begin
            cmd.mul_en  = 1'b1;
            cmd.opb_sel = OPB_S1;
            cmd.acc_add = 1'b1;
          end
          STEP_ACC_B2: begin
            cmd.acc_add = 1'b1;
          end
          STEP_Y: begin
            cmd.y_latch = 1'b1;
            step_next   = STEP_RD_S0;
            if (section == last_sec) begin
              state_next = ST_FINISH;
            end else begin
              section_next = section + SEC_W'(1);
            end
          end
          default: begin
            step_next = STEP_RD_S0;
          end
        endcase
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_rd   = is_rd;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output beat valid: set on load, drop once taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_RD_S0;
      section   <= '0;
      is_rd     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      section   <= section_next;
      is_rd     <= is_rd_next;
      out_valid <= out_valid_next;
    end
  end

  // A filter beat starts at the first step of the first section
  `BIQ_ASSERT_NEXT(a_filt_start, clk, rst, accept && (mode == MODE_FILTER), (state == ST_FILT) && (step == STEP_RD_S0) && (section == '0), "filter did not start at section zero")
  // Filtering leaves only after the last step of the last section
  `BIQ_ASSERT_NEXT(a_filt_hold, clk, rst, (state == ST_FILT) && !((step == STEP_Y) && (section == last_sec)), state == ST_FILT, "filter left early")
  // A readback goes straight to the output stage
  `BIQ_ASSERT_NEXT(a_rd_path, clk, rst, accept && (mode == MODE_READ_STATE), (state == ST_FINISH) && is_rd, "readback not routed to output")
  // A new output beat comes only from the finish stage
  `BIQ_ASSERT_IMPLY(a_out_src, clk, rst, $rose(out_valid), $past(state) == ST_FINISH, "output beat without a finished item")

endmodule

`default_nettype wire
